@@ hw/rtl/inr_pkg.sv @@
// Shared types and constants for the impulse noise neighbor repair block.
// No dependencies; imported by the interfaces, the top level and its submodule.
package inr_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int RST_DIM        = 512;
  localparam int MIN_DIM        = 3;

  localparam logic [PIX_W-1:0] RST_LOW_THR  = 8'd10;
  localparam logic [PIX_W-1:0] RST_HIGH_THR = 8'd250;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 4'd0,
    REG_IMAGE_HEIGHT   = 4'd1,
    REG_LOW_THRESHOLD  = 4'd2,
    REG_HIGH_THRESHOLD = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic interior;
    logic frame_end;
  } repair_ctl_t;

endpackage

@@ hw/rtl/inr_in_if.sv @@
// Pixel request channel: command plus raw pixel.
// Depends on inr_pkg.
interface inr_in_if import inr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, command, pixel_in, input ready);
  modport sink   (input valid, command, pixel_in, output ready);
endinterface

@@ hw/rtl/inr_out_if.sv @@
// Result channel: corrected pixel with replace and frame end flags.
// Depends on inr_pkg.
interface inr_out_if import inr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             was_replaced;
  logic             frame_end;

  modport source (output valid, pixel_out, was_replaced, frame_end, input ready);
  modport sink   (input valid, pixel_out, was_replaced, frame_end, output ready);
endinterface

@@ hw/rtl/inr_cfg_if.sv @@
// Register write channel: register index and write data.
// Depends on inr_pkg.
interface inr_cfg_if import inr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/impulse_noise_neighbor_repair.sv @@
// Top level of the impulse noise neighbor repair block.
// Depends on inr_pkg, inr_in_if, inr_out_if, inr_cfg_if and inr_repair.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid / ready    command, pixel_in
//  out_ch   out  valid / ready    pixel_out, was_replaced, frame_end
//  cfg_ch   in   valid / ready    index, data (ready is always high)
//
// One request per clock sustained. A pixel that a request releases passes
// through the registered reads of the raw line memory (two read ports) and
// the corrected row memory, then through the mean and the output register.
// in_ch.ready drops only while both the read stage and the output register
// hold a result. Synchronous reset; the memories need no clearing pass.
module impulse_noise_neighbor_repair import inr_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  inr_in_if.sink     in_ch,
  inr_out_if.source  out_ch,
  inr_cfg_if.sink    cfg_ch
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int PW    = $clog2(MAX_WIDTH + 2);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int RST_W = (RST_DIM > MAX_WIDTH) ? MAX_WIDTH : RST_DIM;
  localparam int RST_H = (RST_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RST_DIM;

  // configuration
  logic [PW-1:0]    width_r, width_nxt;
  logic [HW-1:0]    height_r, height_nxt;
  logic [PIX_W-1:0] low_r, low_nxt;
  logic [PIX_W-1:0] high_r, high_nxt;

  // stream state
  logic [CW-1:0]    in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0]    in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [PW-1:0]    pend_r, pend_nxt;
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PIX_W-1:0] left_r, left_nxt;
  logic [PIX_W-1:0] newest_r;

  // read stage and output register
  logic             s2_v_r, s2_v_nxt;
  repair_ctl_t      s2_ctl_r;
  logic [CW-1:0]    s2_col_r;
  logic [PIX_W-1:0] s2_bottom_r;
  logic [PIX_W-1:0] rd_cur_r, rd_right_r, rd_top_r;
  logic             out_v_r, out_v_nxt;
  logic [PIX_W-1:0] pix_out_r;
  logic             rep_out_r, fend_out_r;

  logic [PIX_W-1:0] raw_mem [DEPTH];
  logic [PIX_W-1:0] row_mem [MAX_WIDTH];

  logic             acc, in_rdy, s2_go, is_pix, emit, cfg_we;
  logic             pend_full, at_start, in_col_last, in_row_last;
  logic             out_col_last, out_row_last;
  logic [PW-1:0]    w_plus1;
  logic [AW-1:0]    rp_inc, wp_inc;
  logic [31:0]      cfg_ext;
  logic [PW-1:0]    w_clamp;
  logic [HW-1:0]    h_clamp;
  repair_ctl_t      ctl_now;
  logic [PIX_W-1:0] rep_res;
  logic             rep_flag;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  assign s2_go        = s2_v_r && (!out_v_r || out_ch.ready);
  assign in_rdy       = !s2_v_r || s2_go;
  assign in_ch.ready  = in_rdy;
  assign acc          = in_ch.valid && in_rdy;
  assign is_pix       = (in_ch.command == CMD_PIXEL);

  assign w_plus1      = width_r + PW'(1);
  assign pend_full    = (pend_r == w_plus1);
  assign at_start     = (in_col_r == '0) && (in_row_r == '0);
  assign in_col_last  = (PW'(in_col_r) + PW'(1) == width_r);
  assign in_row_last  = (HW'(in_row_r) + HW'(1) == height_r);
  assign out_col_last = (PW'(out_col_r) + PW'(1) == width_r);
  assign out_row_last = (HW'(out_row_r) + HW'(1) == height_r);

  // a flush only drains once the input side sits at the start of a frame
  assign emit = is_pix ? pend_full
                       : (at_start && (pend_r != '0) && (pend_r <= w_plus1));

  assign ctl_now.interior  = (out_row_r != '0) && !out_row_last &&
                             (out_col_r != '0) && !out_col_last && pend_full;
  assign ctl_now.frame_end = out_row_last && out_col_last;

  assign rp_inc = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
  assign wp_inc = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);

  assign cfg_ext = 32'(cfg_ch.data);
  assign w_clamp = (cfg_ext < 32'(MIN_DIM))   ? PW'(MIN_DIM) :
                   (cfg_ext > 32'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(cfg_ext);
  assign h_clamp = (cfg_ext < 32'(MIN_DIM))    ? HW'(MIN_DIM) :
                   (cfg_ext > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_ext);

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pend_nxt    = pend_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    left_nxt    = left_r;
    s2_v_nxt    = s2_v_r;
    out_v_nxt   = out_v_r;

    if (s2_go) begin
      left_nxt = rep_res;
    end
    if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
    if (s2_go) begin
      out_v_nxt = 1'b1;
      s2_v_nxt  = 1'b0;
    end

    if (acc) begin
      if (emit) begin
        s2_v_nxt = 1'b1;
        rp_nxt   = rp_inc;
        if (out_col_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_last ? '0 : out_row_r + RW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
      if (is_pix) begin
        wp_nxt = wp_inc;
        if (!pend_full) begin
          pend_nxt = pend_r + PW'(1);
        end
        if (in_col_last) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_last ? '0 : in_row_r + RW'(1);
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
      end else if (emit) begin
        pend_nxt = pend_r - PW'(1);
      end
    end

    if (cfg_we) begin
      case (cfg_ch.index)
        REG_IMAGE_WIDTH: begin
          width_nxt = w_clamp;
        end
        REG_IMAGE_HEIGHT: begin
          height_nxt = h_clamp;
        end
        REG_LOW_THRESHOLD: begin
          low_nxt = cfg_ch.data[PIX_W-1:0];
        end
        REG_HIGH_THRESHOLD: begin
          high_nxt = cfg_ch.data[PIX_W-1:0];
        end
        default: begin
        end
      endcase
      // geometry change drops pending pixels and restarts the frame
      if ((cfg_ch.index == REG_IMAGE_WIDTH) || (cfg_ch.index == REG_IMAGE_HEIGHT)) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        pend_nxt    = '0;
        rp_nxt      = wp_r;
        left_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= PW'(RST_W);
      height_r  <= HW'(RST_H);
      low_r     <= RST_LOW_THR;
      high_r    <= RST_HIGH_THR;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
      wp_r      <= '0;
      rp_r      <= '0;
      left_r    <= '0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      left_r    <= left_nxt;
      s2_v_r    <= s2_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // raw line: read-first, so the oldest slot can be overwritten in the same cycle
  always_ff @(posedge clk) begin
    if (acc && is_pix) begin
      raw_mem[wp_r] <= in_ch.pixel_in;
    end
    if (acc && emit) begin
      rd_cur_r   <= raw_mem[rp_r];
      rd_right_r <= raw_mem[rp_inc];
    end
  end

  // corrected row above; the write is for the previous column, never the one read
  always_ff @(posedge clk) begin
    if (s2_go) begin
      row_mem[s2_col_r] <= rep_res;
    end
    if (acc && emit) begin
      rd_top_r <= row_mem[out_col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_pix) begin
      newest_r <= in_ch.pixel_in;
    end
    if (acc && emit) begin
      s2_ctl_r    <= ctl_now;
      s2_col_r    <= out_col_r;
      s2_bottom_r <= newest_r;
    end
    if (s2_go) begin
      pix_out_r  <= rep_res;
      rep_out_r  <= rep_flag;
      fend_out_r <= s2_ctl_r.frame_end;
    end
  end

  inr_repair u_repair (
    .cur      (rd_cur_r),
    .top      (rd_top_r),
    .right    (rd_right_r),
    .bottom   (s2_bottom_r),
    .left     (left_r),
    .low_thr  (low_r),
    .high_thr (high_r),
    .interior (s2_ctl_r.interior),
    .res      (rep_res),
    .replaced (rep_flag)
  );

  assign out_ch.valid        = out_v_r;
  assign out_ch.pixel_out    = pix_out_r;
  assign out_ch.was_replaced = rep_out_r;
  assign out_ch.frame_end    = fend_out_r;

endmodule

@@ hw/rtl/inr_repair.sv @@
// Noise test and four-neighbor rounded mean for one pending pixel.
// Depends on inr_pkg.
module inr_repair import inr_pkg::*; (
  input  logic [PIX_W-1:0] cur,
  input  logic [PIX_W-1:0] top,
  input  logic [PIX_W-1:0] right,
  input  logic [PIX_W-1:0] bottom,
  input  logic [PIX_W-1:0] left,
  input  logic [PIX_W-1:0] low_thr,
  input  logic [PIX_W-1:0] high_thr,
  input  logic             interior,
  output logic [PIX_W-1:0] res,
  output logic             replaced
);
  logic [SUM_W-1:0] sum;
  logic             noisy;

  assign sum = SUM_W'(top) + SUM_W'(right) + SUM_W'(bottom) + SUM_W'(left) + SUM_W'(2);
  assign noisy    = (cur < low_thr) || (cur > high_thr);
  assign replaced = interior && noisy;
  assign res      = replaced ? sum[SUM_W-1:2] : cur;
endmodule

@@ hw/rtl/inr_checker.sv @@
// Port-level checks for impulse_noise_neighbor_repair, attached by bind.
// Depends on inr_pkg and the top level's interface ports.
module inr_checker import inr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] pixel_out,
  input logic             was_replaced,
  input logic             frame_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) &&
    $stable(was_replaced) && $stable(frame_end))
    else $error("stalled result changed");

  // a new result always comes from an accepted request, by way of the read stage
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a request");

  // input backpressure only while the output side is full and stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with output free");

  // the last pixel of a frame is a corner and is never replaced
  a_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> !was_replaced)
    else $error("frame corner replaced");

endmodule

bind impulse_noise_neighbor_repair inr_checker u_inr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pixel_out    (out_ch.pixel_out),
  .was_replaced (out_ch.was_replaced),
  .frame_end    (out_ch.frame_end)
);
